[rtl/core/gws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gws_pkg
// Shared types and constants for the eight-direction grid word search core.
// ----------------------------------------------------------------------------
package gws_pkg;

    localparam int DEF_MAX_GRID = 32;
    localparam int DEF_MAX_WORD = 64;

    localparam logic [5:0] HIT_CAP         = 6'd63;
    localparam logic [7:0] SPACE_BYTE      = 8'd32;
    localparam logic [5:0] GRID_SIZE_RESET = 6'd32;

    localparam logic MODE_CELL = 1'b0;
    localparam logic MODE_WORD = 1'b1;

    // word index of the APB register (paddr[2])
    localparam logic REG_GRID_SIZE = 1'b0;

    localparam logic [2:0] DIR_N  = 3'd0;
    localparam logic [2:0] DIR_NE = 3'd1;
    localparam logic [2:0] DIR_E  = 3'd2;
    localparam logic [2:0] DIR_SE = 3'd3;
    localparam logic [2:0] DIR_S  = 3'd4;
    localparam logic [2:0] DIR_SW = 3'd5;
    localparam logic [2:0] DIR_W  = 3'd6;
    localparam logic [2:0] DIR_NW = 3'd7;

    typedef struct packed {
        logic       mode;
        logic [4:0] cell_row;
        logic [4:0] cell_col;
        logic [7:0] symbol;
        logic       word_end;
    } gws_cmd_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] hit_row;
        logic [5:0] hit_col;
        logic [2:0] direction;
        logic       overflow;
        logic       last_result;
    } gws_result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CELL_RD,
        S_CELL_CMP,
        S_PATH_STEP,
        S_PATH_CMP,
        S_NEXT_CELL
    } gws_state_t;

endpackage

[rtl/core/grid_word_search_eight_dir_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_word_search_eight_dir_core
// Square byte grid and word store in synchronous RAM; the final word byte
// starts a sequential scan of all start cells and eight directions.
// ----------------------------------------------------------------------------
// Grid writes and word bytes other than the final one keep busy low. The byte
// with word_end raises busy for the search, which runs on the grid and word
// RAMs (one read each per cycle, registered read data): each start cell is
// read, compared with the first word byte and then stepped past; where they
// match, each of the eight directions is followed cell by cell, a read and a
// compare per grid cell visited, until a full match, the grid edge or a
// mismatching byte ends it. The search stops at once when a 64th hit is
// found. With grid_size zero the not-found result follows on the next cycle
// and busy stays low. Results come out as one-cycle result_valid strobes with
// no back-pressure; the final one carries last_result and busy is already low
// while it is shown. A hit is held one step so that overflow and last_result
// are known when it is presented.
module grid_word_search_eight_dir_core
    import gws_pkg::*;
#(
    parameter int MAX_GRID = DEF_MAX_GRID,
    parameter int MAX_WORD = DEF_MAX_WORD
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  gws_cmd_t    cmd,
    output logic        result_valid,
    output gws_result_t result
);

    localparam int CW         = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int SW         = CW + 1;
    localparam int AW         = 2 * CW;
    localparam int GRID_DEPTH = 1 << AW;
    localparam int LW         = $clog2(MAX_WORD + 1);
    localparam int WW         = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

    // ---------------------------------------------------------------- APB
    logic [5:0] grid_size_reg;
    logic       cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_GRID_SIZE);
    assign prdata = (paddr[2] == REG_GRID_SIZE) ? {26'd0, grid_size_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GRID_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            grid_size_reg <= pwdata[5:0];
        end
    end

    logic [SW-1:0] side;
    assign side = (32'(grid_size_reg) > MAX_GRID) ? SW'(MAX_GRID) : SW'(grid_size_reg);

    // ---------------------------------------------------------------- state
    gws_state_t    state_reg, state_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    logic [CW-1:0] rr_reg, rr_next;
    logic [CW-1:0] cc_reg, cc_next;
    logic [2:0]    d_reg, d_next;
    logic [LW-1:0] j_reg, j_next;
    logic [LW-1:0] len_reg, len_next;
    logic [5:0]    hit_cnt_reg, hit_cnt_next;
    gws_result_t   pend_reg, pend_next;
    logic          res_valid_reg, res_valid_next;
    gws_result_t   res_reg, res_next;

    logic          accept;
    logic          grid_we;
    logic [AW-1:0] grid_waddr;
    logic [AW-1:0] grid_raddr;
    logic [7:0]    grid_q;
    logic          word_we;
    logic [WW-1:0] word_waddr;
    logic [WW-1:0] word_raddr;
    logic [7:0]    word_q;

    logic          row_dec, row_inc, col_dec, col_inc;
    logic          step_out;
    logic [CW-1:0] rr_step, cc_step;
    gws_result_t   new_hit;
    gws_result_t   not_found;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    assign grid_we    = accept && (cmd.mode == MODE_CELL) && (32'(cmd.cell_row) < MAX_GRID)
                        && (32'(cmd.cell_col) < MAX_GRID);
    assign grid_waddr = {CW'(cmd.cell_row), CW'(cmd.cell_col)};
    assign word_we    = accept && (cmd.mode == MODE_WORD) && (len_reg < LW'(MAX_WORD));
    assign word_waddr = WW'(len_reg);

    // ---------------------------------------------------------------- memories
    logic [7:0] grid_mem [GRID_DEPTH];
    logic [7:0] word_mem [MAX_WORD];

    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[grid_waddr] <= cmd.symbol;
        end
        grid_q <= grid_mem[grid_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[word_waddr] <= cmd.symbol;
        end
        word_q <= word_mem[word_raddr];
    end

    // ---------------------------------------------------------------- path step
    always_comb
    begin
        row_dec = 1'b0;
        row_inc = 1'b0;
        col_dec = 1'b0;
        col_inc = 1'b0;
        case (d_reg) inside
            DIR_N, DIR_NE, DIR_NW: row_dec = 1'b1;
            DIR_SE, DIR_S, DIR_SW: row_inc = 1'b1;
            default:               row_dec = 1'b0;
        endcase
        case (d_reg) inside
            DIR_NE, DIR_E, DIR_SE: col_inc = 1'b1;
            DIR_SW, DIR_W, DIR_NW: col_dec = 1'b1;
            default:               col_inc = 1'b0;
        endcase
    end

    assign step_out = (row_dec && (rr_reg == '0))
                   || (row_inc && ((SW'(rr_reg) + SW'(1)) >= side))
                   || (col_dec && (cc_reg == '0))
                   || (col_inc && ((SW'(cc_reg) + SW'(1)) >= side));

    assign rr_step = row_dec ? (rr_reg - CW'(1)) : (row_inc ? (rr_reg + CW'(1)) : rr_reg);
    assign cc_step = col_dec ? (cc_reg - CW'(1)) : (col_inc ? (cc_reg + CW'(1)) : cc_reg);

    always_comb
    begin
        new_hit             = '0;
        new_hit.hit         = 1'b1;
        new_hit.hit_row     = 6'(SW'(r_reg) + SW'(1));
        new_hit.hit_col     = 6'(SW'(c_reg) + SW'(1));
        new_hit.direction   = d_reg;
        not_found           = '0;
        not_found.last_result = 1'b1;
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            hit_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            hit_cnt_reg   <= hit_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        c_reg    <= c_next;
        rr_reg   <= rr_next;
        cc_reg   <= cc_next;
        d_reg    <= d_next;
        j_reg    <= j_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        rr_next        = rr_reg;
        cc_next        = cc_reg;
        d_next         = d_reg;
        j_next         = j_reg;
        len_next       = len_reg;
        hit_cnt_next   = hit_cnt_reg;
        pend_next      = pend_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        grid_raddr     = {rr_reg, cc_reg};
        word_raddr     = WW'(j_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.mode == MODE_WORD))
                begin
                    if (len_reg < LW'(MAX_WORD))
                    begin
                        len_next = len_reg + LW'(1);
                    end
                    if (cmd.word_end)
                    begin
                        hit_cnt_next = '0;
                        r_next       = '0;
                        c_next       = '0;
                        if (side == '0)
                        begin
                            res_valid_next = 1'b1;
                            res_next       = not_found;
                            len_next       = '0;
                        end
                        else
                        begin
                            state_next = S_CELL_RD;
                        end
                    end
                end
            end

            S_CELL_RD:
            begin
                grid_raddr = {r_reg, c_reg};
                word_raddr = '0;
                state_next = S_CELL_CMP;
            end

            S_CELL_CMP:
            begin
                if (grid_q == word_q)
                begin
                    d_next     = DIR_N;
                    rr_next    = r_reg;
                    cc_next    = c_reg;
                    j_next     = LW'(1);
                    state_next = S_PATH_STEP;
                end
                else
                begin
                    state_next = S_NEXT_CELL;
                end
            end

            S_PATH_STEP:
            begin
                if (j_reg >= len_reg)
                begin
                    if (hit_cnt_reg == HIT_CAP)
                    begin
                        res_valid_next       = 1'b1;
                        res_next             = pend_reg;
                        res_next.overflow    = 1'b1;
                        res_next.last_result = 1'b1;
                        len_next             = '0;
                        state_next           = S_IDLE;
                    end
                    else
                    begin
                        if (hit_cnt_reg != '0)
                        begin
                            res_valid_next = 1'b1;
                            res_next       = pend_reg;
                        end
                        pend_next    = new_hit;
                        hit_cnt_next = hit_cnt_reg + 6'd1;
                        if (d_reg == DIR_NW)
                        begin
                            state_next = S_NEXT_CELL;
                        end
                        else
                        begin
                            d_next  = d_reg + 3'd1;
                            rr_next = r_reg;
                            cc_next = c_reg;
                            j_next  = LW'(1);
                        end
                    end
                end
                else if (step_out)
                begin
                    if (d_reg == DIR_NW)
                    begin
                        state_next = S_NEXT_CELL;
                    end
                    else
                    begin
                        d_next  = d_reg + 3'd1;
                        rr_next = r_reg;
                        cc_next = c_reg;
                        j_next  = LW'(1);
                    end
                end
                else
                begin
                    rr_next    = rr_step;
                    cc_next    = cc_step;
                    grid_raddr = {rr_step, cc_step};
                    state_next = S_PATH_CMP;
                end
            end

            S_PATH_CMP:
            begin
                if (grid_q == SPACE_BYTE)
                begin
                    state_next = S_PATH_STEP;
                end
                else if (grid_q == word_q)
                begin
                    j_next     = j_reg + LW'(1);
                    state_next = S_PATH_STEP;
                end
                else if (d_reg == DIR_NW)
                begin
                    state_next = S_NEXT_CELL;
                end
                else
                begin
                    d_next     = d_reg + 3'd1;
                    rr_next    = r_reg;
                    cc_next    = c_reg;
                    j_next     = LW'(1);
                    state_next = S_PATH_STEP;
                end
            end

            S_NEXT_CELL:
            begin
                if ((SW'(c_reg) + SW'(1)) < side)
                begin
                    c_next     = c_reg + CW'(1);
                    state_next = S_CELL_RD;
                end
                else if ((SW'(r_reg) + SW'(1)) < side)
                begin
                    r_next     = r_reg + CW'(1);
                    c_next     = '0;
                    state_next = S_CELL_RD;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    if (hit_cnt_reg != '0)
                    begin
                        res_next             = pend_reg;
                        res_next.last_result = 1'b1;
                    end
                    else
                    begin
                        res_next = not_found;
                    end
                    len_next   = '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // ---------------------------------------------------------------- checks
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last_result |-> !busy)
        else $error("last result shown while search still running");

    a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.overflow |-> result.last_result)
        else $error("overflow on a result that is not the last");

    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.hit |-> result.last_result && (result.hit_row == 6'd0))
        else $error("malformed not-found result");

    a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.mode == MODE_WORD) && cmd.word_end
        |=> busy || (result_valid && result.last_result))
        else $error("final word byte did not start a search");

endmodule

[dv/grid_word_search_eight_dir_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_word_search_eight_dir_core_tb
// Self-checking bench for the eight-direction grid word search core. Grid
// cell writes and word bytes go in through start/busy; a built-in predictor
// tracks the grid, word and grid_size register and computes the expected
// hit list (cap, overflow, not-found, space skipping) for each word. Every
// result strobe is checked field by field against the oldest expected hit.
// A directed block comes first, then random rounds that change grid_size,
// rewrite cells and search words walked out of the grid plus noise words,
// under several sender idle rates.
// ----------------------------------------------------------------------------
module grid_word_search_eight_dir_core_tb;
    import gws_pkg::*;

    localparam logic [2:0] ADDR_GRID_SIZE = {REG_GRID_SIZE, 2'b00};
    localparam logic [7:0] CH_A = "A";
    localparam logic [7:0] CH_B = "B";
    localparam logic [7:0] CH_C = "C";
    localparam logic [7:0] CH_Z = "Z";
    localparam int PHASE_ITEMS = 85;
    localparam int SETTLE_CYCLES = 8;
    localparam int FILL_SIDE = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    gws_cmd_t    cmd = '0;
    logic        result_valid;
    gws_result_t result;

    gws_cmd_t    cmd_backlog[$];
    gws_result_t hits_due[$];
    logic [7:0]  word_buf[$];

    logic [7:0]  model_grid [DEF_MAX_GRID][DEF_MAX_GRID];
    logic [7:0]  plan_grid [DEF_MAX_GRID][DEF_MAX_GRID];
    logic [7:0]  model_word [DEF_MAX_WORD];
    int          model_len = 0;
    logic [5:0]  model_size = GRID_SIZE_RESET;

    int cmds_queued = 0;
    int cmds_taken = 0;
    int results_seen = 0;
    int errors = 0;
    int send_idle_pct = 0;

    grid_word_search_eight_dir_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic int row_step(logic [2:0] d);
        case (d)
            DIR_N, DIR_NE, DIR_NW: return -1;
            DIR_SE, DIR_S, DIR_SW: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic int col_step(logic [2:0] d);
        case (d)
            DIR_NE, DIR_E, DIR_SE: return 1;
            DIR_SW, DIR_W, DIR_NW: return -1;
            default: return 0;
        endcase
    endfunction

    function automatic bit path_hits(int r, int c, int d, int side);
        int rr;
        int cc;
        int j;
        rr = r;
        cc = c;
        j = 1;
        while (j < model_len)
        begin
            rr += row_step(3'(d));
            cc += col_step(3'(d));
            if (rr < 0 || rr >= side || cc < 0 || cc >= side)
                return 1'b0;
            if (model_grid[rr][cc] == SPACE_BYTE)
                continue;
            if (model_grid[rr][cc] != model_word[j])
                return 1'b0;
            j++;
        end
        return 1'b1;
    endfunction

    // the newest hit is held back so overflow/last can be set on it
    function automatic void search_grid();
        int side;
        int count;
        bit over;
        bit held;
        gws_result_t pend;
        side = (model_size > DEF_MAX_GRID) ? DEF_MAX_GRID : int'(model_size);
        count = 0;
        over = 1'b0;
        held = 1'b0;
        pend = '0;
        for (int r = 0; r < side && !over; r++)
            for (int c = 0; c < side && !over; c++)
            begin
                if (model_len == 0 || model_grid[r][c] != model_word[0])
                    continue;
                for (int d = 0; d < 8; d++)
                begin
                    if (!path_hits(r, c, d, side))
                        continue;
                    if (count >= int'(HIT_CAP))
                    begin
                        over = 1'b1;
                        break;
                    end
                    if (held)
                        hits_due.push_back(pend);
                    pend = '0;
                    pend.hit = 1'b1;
                    pend.hit_row = 6'(r + 1);
                    pend.hit_col = 6'(c + 1);
                    pend.direction = 3'(d);
                    held = 1'b1;
                    count++;
                end
            end
        if (!held)
            pend = '0;
        pend.overflow = over;
        pend.last_result = 1'b1;
        hits_due.push_back(pend);
    endfunction

    function automatic void apply_cmd(gws_cmd_t c);
        if (c.mode == MODE_CELL)
            model_grid[c.cell_row][c.cell_col] = c.symbol;
        else
        begin
            if (model_len < DEF_MAX_WORD)
            begin
                model_word[model_len] = c.symbol;
                model_len++;
            end
            if (c.word_end)
            begin
                search_grid();
                model_len = 0;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // driver and monitor
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_cmd(cmd);
                cmds_taken++;
            end
            if (!start || !busy)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd <= cmd_backlog.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(string msg);
        if (errors < 50)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("transaction %0d %s got %0d want %0d",
                                      results_seen, name, got, want));
    endtask

    always @(posedge clk)
    begin
        gws_result_t want;
        if (rst_n && result_valid)
        begin
            if (hits_due.size() == 0)
                report_mismatch($sformatf("transaction %0d with no expected result",
                                          results_seen));
            else
            begin
                want = hits_due.pop_front();
                check_field("hit", int'(result.hit), int'(want.hit));
                check_field("hit_row", int'(result.hit_row), int'(want.hit_row));
                check_field("hit_col", int'(result.hit_col), int'(want.hit_col));
                check_field("direction", int'(result.direction), int'(want.direction));
                check_field("overflow", int'(result.overflow), int'(want.overflow));
                check_field("last_result", int'(result.last_result),
                            int'(want.last_result));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_sym();
        int k;
        k = $urandom_range(99);
        if (k < 10)
            return 8'($urandom_range(255));
        else if (k < 30)
            return SPACE_BYTE;
        else if (k < 55)
            return CH_A;
        else if (k < 80)
            return CH_B;
        else
            return CH_C;
    endfunction

    task automatic queue_cell(logic [4:0] row, logic [4:0] col, logic [7:0] sym,
                              logic flag);
        gws_cmd_t c;
        c.mode = MODE_CELL;
        c.cell_row = row;
        c.cell_col = col;
        c.symbol = sym;
        c.word_end = flag;
        plan_grid[row][col] = sym;
        cmd_backlog.push_back(c);
        cmds_queued++;
    endtask

    task automatic queue_word();
        gws_cmd_t c;
        for (int i = 0; i < word_buf.size(); i++)
        begin
            c.mode = MODE_WORD;
            c.cell_row = 5'($urandom_range(31));
            c.cell_col = 5'($urandom_range(31));
            c.symbol = word_buf[i];
            c.word_end = (i == word_buf.size() - 1);
            cmd_backlog.push_back(c);
            cmds_queued++;
        end
    endtask

    task automatic build_noise_word();
        int len;
        len = ($urandom_range(19) == 0) ? $urandom_range(66, 70) : $urandom_range(1, 4);
        word_buf.delete();
        repeat (len)
            word_buf.push_back(pick_sym());
    endtask

    // word read along a grid line, spaces dropped; sometimes last byte broken
    task automatic build_walk_word(int side);
        int r;
        int c;
        int d;
        int len;
        if (side == 0)
        begin
            build_noise_word();
            return;
        end
        r = $urandom_range(side - 1);
        c = $urandom_range(side - 1);
        d = $urandom_range(7);
        len = $urandom_range(1, 5);
        word_buf.delete();
        word_buf.push_back(plan_grid[r][c]);
        while (word_buf.size() < len)
        begin
            r += row_step(3'(d));
            c += col_step(3'(d));
            if (r < 0 || r >= side || c < 0 || c >= side)
                break;
            if (plan_grid[r][c] != SPACE_BYTE)
                word_buf.push_back(plan_grid[r][c]);
        end
        if ($urandom_range(4) == 0)
            word_buf[word_buf.size() - 1] = pick_sym();
    endtask

    task automatic queue_random_cell(int side);
        if (side > 0 && $urandom_range(1) == 0)
            queue_cell(5'($urandom_range(side - 1)), 5'($urandom_range(side - 1)),
                       pick_sym(), 1'($urandom_range(1)));
        else
            queue_cell(5'($urandom_range(31)), 5'($urandom_range(31)), pick_sym(),
                       1'($urandom_range(1)));
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (cmds_taken != cmds_queued || hits_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_grid_size(logic [5:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_GRID_SIZE;
        pwdata <= {26'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model_size = value;
    endtask

    task automatic run_round(int pct);
        int pick;
        int side;
        logic [5:0] sz;
        drain();
        send_idle_pct = ($urandom_range(3) == 0) ? 0 : pct;
        pick = $urandom_range(99);
        if (pick < 5)
            sz = 6'd0;
        else
            sz = 6'($urandom_range(1, FILL_SIDE));
        write_grid_size(sz);
        side = (sz > DEF_MAX_GRID) ? DEF_MAX_GRID : int'(sz);
        repeat ($urandom_range(0, 12))
            queue_random_cell(side);
        repeat ($urandom_range(3, 6))
        begin
            if ($urandom_range(9) < 3)
                queue_random_cell(side);
            if ($urandom_range(9) < 7)
                build_walk_word(side);
            else
                build_noise_word();
            queue_word();
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int mark;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // 3x3 of 'A', single-letter word: 72 hits, capped with overflow
        drain();
        write_grid_size(6'd3);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                queue_cell(5'(r), 5'(c), CH_A, 1'(r == c));
        word_buf = '{CH_A};
        queue_word();
        // space on the path is stepped over
        queue_cell(5'd0, 5'd1, SPACE_BYTE, 1'b0);
        queue_cell(5'd0, 5'd2, CH_B, 1'b1);
        word_buf = '{CH_A, CH_B};
        queue_word();
        word_buf = '{CH_Z};
        queue_word();
        word_buf = '{8'h00, 8'hFF};
        queue_word();
        drain();
        write_grid_size(6'd0);
        word_buf = '{CH_A};
        queue_word();
        drain();
        write_grid_size(6'd1);
        word_buf = '{CH_A};
        queue_word();

        // fill the top-left block so every grid size used reads written cells only
        drain();
        write_grid_size(6'(FILL_SIDE));
        for (int r = 0; r < FILL_SIDE; r++)
            for (int c = 0; c < FILL_SIDE; c++)
                queue_cell(5'(r), 5'(c), pick_sym(), 1'($urandom_range(1)));
        queue_cell(5'd31, 5'd31, 8'hFF, 1'b0);
        queue_cell(5'd31, 5'd0, 8'h00, 1'b1);
        build_walk_word(FILL_SIDE);
        queue_word();
        build_noise_word();
        queue_word();

        // phases: no idling, sender idle 47%, no idling again (receiver cannot stall), sender idle 32%
        for (int ph = 0; ph < 4; ph++)
        begin
            mark = cmds_queued;
            while (cmds_queued - mark < PHASE_ITEMS)
                run_round((ph == 1) ? 47 : (ph == 3) ? 32 : 0);
        end

        drain();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[grid_word_search_eight_dir_core.f]
rtl/core/gws_pkg.sv
rtl/core/grid_word_search_eight_dir_core.sv
dv/grid_word_search_eight_dir_core_tb.sv
